FILE: hdl/mi3_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants and types of the 3x3 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int N_ENT          = 9;
    localparam int N_COL          = 3;

    // Operands of each adjugate entry p*q - r*s, as row-major entry indexes.
    localparam int MINOR_IDX [N_ENT][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

    // Sign information that travels beside the magnitudes into the divider.
    typedef struct packed {
        logic             zero;
        logic             neg;
        logic [N_ENT-1:0] aneg;
    } t_sgn;

endpackage
`default_nettype wire

FILE: hdl/mi3_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_if
// Channel interfaces: the input matrix and the result inverse.
// ----------------------------------------------------------------------------
interface mi3_in_if #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  output ready);
endinterface

interface mi3_out_if #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] r00, r01, r02, r10, r11, r12, r20, r21, r22;
    logic                         singular;
    logic                         clipped;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    singular, clipped, input ready);
    modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                  singular, clipped, output ready);
endinterface
`default_nettype wire

FILE: hdl/mi3_cofactor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_cofactor
// Two stages: the eighteen 2x2 products, then the nine signed minors.
// ----------------------------------------------------------------------------
module mi3_cofactor #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [DATA_WIDTH-1:0]   i_a [mi3_pkg::N_ENT],
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic signed [2*DATA_WIDTH:0]        o_adj [mi3_pkg::N_ENT],
    output logic signed [DATA_WIDTH-1:0]        o_col [mi3_pkg::N_COL]
);
    localparam int PW = 2 * DATA_WIDTH;
    localparam int AW = PW + 1;

    logic en0, en1;
    logic r_v0, r_v1;
    logic signed [PW-1:0]         n_p [mi3_pkg::N_ENT];
    logic signed [PW-1:0]         n_q [mi3_pkg::N_ENT];
    logic signed [PW-1:0]         r_p [mi3_pkg::N_ENT];
    logic signed [PW-1:0]         r_q [mi3_pkg::N_ENT];
    logic signed [AW-1:0]         n_adj [mi3_pkg::N_ENT];
    logic signed [AW-1:0]         r_adj [mi3_pkg::N_ENT];
    logic signed [DATA_WIDTH-1:0] r_col0 [mi3_pkg::N_COL];
    logic signed [DATA_WIDTH-1:0] r_col1 [mi3_pkg::N_COL];

    assign en1     = !r_v1 || i_ready;
    assign en0     = !r_v0 || en1;
    assign o_ready = en0;
    assign o_valid = r_v1;
    assign o_adj   = r_adj;
    assign o_col   = r_col1;

    always_comb begin
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            n_p[k] = i_a[mi3_pkg::MINOR_IDX[k][0]] * i_a[mi3_pkg::MINOR_IDX[k][1]];
            n_q[k] = i_a[mi3_pkg::MINOR_IDX[k][2]] * i_a[mi3_pkg::MINOR_IDX[k][3]];
            n_adj[k] = AW'(r_p[k]) - AW'(r_q[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            if (en0) r_v0 <= i_valid;
            if (en1) r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_p    <= n_p;
            r_q    <= n_q;
            r_col0 <= '{i_a[0], i_a[3], i_a[6]};
        end
        if (en1) begin
            r_adj  <= n_adj;
            r_col1 <= r_col0;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mi3_det.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_det
// Four stages: split products of the first column with its cofactors, the
// three terms, their sum, and the magnitudes and signs for the divider.
// ----------------------------------------------------------------------------
module mi3_det #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic signed [2*DATA_WIDTH:0]   i_adj [mi3_pkg::N_ENT],
    input  wire logic signed [DATA_WIDTH-1:0]   i_col [mi3_pkg::N_COL],
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [3*DATA_WIDTH+2:0]             o_dmag,
    output logic [2*DATA_WIDTH:0]               o_mag [mi3_pkg::N_ENT],
    output mi3_pkg::t_sgn                       o_sgn
);
    localparam int W  = DATA_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    logic [3:0] r_v;
    logic [4:0] en;
    logic signed [AW-1:0] n_pl [mi3_pkg::N_COL];
    logic signed [AW-1:0] n_ph [mi3_pkg::N_COL];
    logic signed [AW-1:0] r_pl [mi3_pkg::N_COL];
    logic signed [AW-1:0] r_ph [mi3_pkg::N_COL];
    logic signed [DW-1:0] n_t [mi3_pkg::N_COL];
    logic signed [DW-1:0] r_t [mi3_pkg::N_COL];
    logic signed [DW-1:0] n_det;
    logic signed [DW-1:0] r_det;
    logic signed [AW-1:0] r_adj0 [mi3_pkg::N_ENT];
    logic signed [AW-1:0] r_adj1 [mi3_pkg::N_ENT];
    logic signed [AW-1:0] r_adj2 [mi3_pkg::N_ENT];
    logic [DW-1:0]        n_dmag;
    logic [DW-1:0]        r_dmag;
    logic [AW-1:0]        n_mag [mi3_pkg::N_ENT];
    logic [AW-1:0]        r_mag [mi3_pkg::N_ENT];
    mi3_pkg::t_sgn        n_sgn;
    mi3_pkg::t_sgn        r_sgn;

    always_comb begin
        en[4] = i_ready;
        for (int s = 3; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[3];
    assign o_dmag  = r_dmag;
    assign o_mag   = r_mag;
    assign o_sgn   = r_sgn;

    // The wide cofactor is cut into an unsigned low word and a signed high part.
    always_comb begin
        for (int j = 0; j < mi3_pkg::N_COL; j++) begin
            n_pl[j] = i_col[j] * $signed({1'b0, i_adj[j][W-1:0]});
            n_ph[j] = i_col[j] * $signed(i_adj[j][AW-1:W]);
            n_t[j]  = (DW'(r_ph[j]) <<< W) + DW'(r_pl[j]);
        end
        n_det = r_t[0] + r_t[1] + r_t[2];
        n_dmag = r_det[DW-1] ? DW'(-r_det) : DW'(r_det);
        n_sgn.zero = (r_det == '0);
        n_sgn.neg  = r_det[DW-1];
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            n_mag[k]       = r_adj2[k][AW-1] ? AW'(-r_adj2[k]) : AW'(r_adj2[k]);
            n_sgn.aneg[k]  = r_adj2[k][AW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s < 4; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_pl   <= n_pl;
            r_ph   <= n_ph;
            r_adj0 <= i_adj;
        end
        if (en[1]) begin
            r_t    <= n_t;
            r_adj1 <= r_adj0;
        end
        if (en[2]) begin
            r_det  <= n_det;
            r_adj2 <= r_adj1;
        end
        if (en[3]) begin
            r_dmag <= n_dmag;
            r_mag  <= n_mag;
            r_sgn  <= n_sgn;
        end
    end
endmodule
`default_nettype wire

FILE: hdl/mi3_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_divider
// Nine restoring dividers in lockstep, one quotient bit per stage. A first
// stage scales the numerators and flags quotients too large for the word.
// ----------------------------------------------------------------------------
module mi3_divider #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_ready,
    input  wire logic [3*DATA_WIDTH+2:0]    i_dmag,
    input  wire logic [2*DATA_WIDTH:0]      i_mag [mi3_pkg::N_ENT],
    input  wire mi3_pkg::t_sgn              i_sgn,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [DATA_WIDTH-1:0]           o_q [mi3_pkg::N_ENT],
    output logic [mi3_pkg::N_ENT-1:0]       o_ovf,
    output mi3_pkg::t_sgn                   o_sgn
);
    localparam int W   = DATA_WIDTH;
    localparam int AW  = 2 * W + 1;
    localparam int DW  = 3 * W + 3;
    localparam int NW  = AW + 2 * FRAC_BITS;
    localparam int DSW = DW + W;
    localparam int CW  = ((NW > DSW) ? NW : DSW) + 1;
    localparam int NS  = W + 1;

    logic [NS-1:0] r_v;
    logic [NS:0]   en;
    logic [CW-1:0]             r_rem  [NS][mi3_pkg::N_ENT];
    logic [CW-1:0]             n_rem  [NS][mi3_pkg::N_ENT];
    logic [W-1:0]              r_q    [NS][mi3_pkg::N_ENT];
    logic [W-1:0]              n_q    [NS][mi3_pkg::N_ENT];
    logic [mi3_pkg::N_ENT-1:0] r_ovf  [NS];
    logic [mi3_pkg::N_ENT-1:0] n_ovf0;
    logic [DW-1:0]             r_dmag [NS];
    mi3_pkg::t_sgn             r_sgn  [NS];
    logic [CW-1:0]             dsh    [NS];

    always_comb begin
        en[NS] = i_ready;
        for (int s = NS - 1; s >= 0; s--) begin
            en[s] = !r_v[s] || en[s+1];
        end
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NS-1];
    assign o_q     = r_q[NS-1];
    assign o_ovf   = r_ovf[NS-1];
    assign o_sgn   = r_sgn[NS-1];

    always_comb begin
        dsh[0] = CW'(i_dmag) << W;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            n_rem[0][k] = CW'(i_mag[k]) << (2 * FRAC_BITS);
            n_q[0][k]   = '0;
            n_ovf0[k]   = (n_rem[0][k] >= dsh[0]);
        end
        // Stage s settles quotient bit W-s against the divisor shifted to match.
        for (int s = 1; s < NS; s++) begin
            dsh[s] = CW'(r_dmag[s-1]) << (W - s);
            for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
                if (r_rem[s-1][k] >= dsh[s]) begin
                    n_rem[s][k] = r_rem[s-1][k] - dsh[s];
                    n_q[s][k]   = r_q[s-1][k] | (W'(1) << (W - s));
                end else begin
                    n_rem[s][k] = r_rem[s-1][k];
                    n_q[s][k]   = r_q[s-1][k];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int s = 1; s < NS; s++) begin
                if (en[s]) r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_rem[0]  <= n_rem[0];
            r_q[0]    <= n_q[0];
            r_ovf[0]  <= n_ovf0;
            r_dmag[0] <= i_dmag;
            r_sgn[0]  <= i_sgn;
        end
        for (int s = 1; s < NS; s++) begin
            if (en[s]) begin
                r_rem[s]  <= n_rem[s];
                r_q[s]    <= n_q[s];
                r_ovf[s]  <= r_ovf[s-1];
                r_dmag[s] <= r_dmag[s-1];
                r_sgn[s]  <= r_sgn[s-1];
            end
        end
    end
endmodule
`default_nettype wire

FILE: hdl/matrix_inverse_3x3.sv
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 matrix inverter by the adjugate, signed fixed point.
// ----------------------------------------------------------------------------
// The block takes one matrix per clock cycle while no stall holds it, in the
// default Q16.16 format or as DATA_WIDTH and FRAC_BITS set; its pipeline
// depth is set by the nine dividers, which settle one quotient bit per stage.
// Every entry is the adjugate entry scaled by 2^(2*FRAC_BITS) and divided by
// the determinant, truncated toward zero and saturated to the word range, in
// which case clipped is set. A zero determinant gives an all-zero result with
// singular set. Backpressure on the output stalls only the stages that hold
// data, so bubbles are squeezed out and no transaction is lost or repeated.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int DATA_WIDTH = mi3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = mi3_pkg::FRAC_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mi3_in_if.sink      i_mat,
    mi3_out_if.source   o_inv
);
    localparam int W  = DATA_WIDTH;
    localparam int AW = 2 * W + 1;
    localparam int DW = 3 * W + 3;

    logic signed [W-1:0]  a [mi3_pkg::N_ENT];
    logic                 cf_valid, cf_ready;
    logic signed [AW-1:0] cf_adj [mi3_pkg::N_ENT];
    logic signed [W-1:0]  cf_col [mi3_pkg::N_COL];
    logic                 dt_valid, dt_ready;
    logic [DW-1:0]        dt_dmag;
    logic [AW-1:0]        dt_mag [mi3_pkg::N_ENT];
    mi3_pkg::t_sgn        dt_sgn;
    logic                 dv_valid, dv_ready;
    logic [W-1:0]         dv_q [mi3_pkg::N_ENT];
    logic [mi3_pkg::N_ENT-1:0] dv_ovf;
    mi3_pkg::t_sgn        dv_sgn;

    logic                 r_ov;
    logic [W-1:0]         n_r [mi3_pkg::N_ENT];
    logic [W-1:0]         r_r [mi3_pkg::N_ENT];
    logic                 n_clip, r_clip, r_sing;
    logic [mi3_pkg::N_ENT-1:0] sat;

    assign a = '{i_mat.a00, i_mat.a01, i_mat.a02, i_mat.a10, i_mat.a11,
                 i_mat.a12, i_mat.a20, i_mat.a21, i_mat.a22};

    mi3_cofactor #(.DATA_WIDTH(W)) u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_mat.valid),
        .o_ready (i_mat.ready),
        .i_a     (a),
        .o_valid (cf_valid),
        .i_ready (cf_ready),
        .o_adj   (cf_adj),
        .o_col   (cf_col)
    );

    mi3_det #(.DATA_WIDTH(W)) u_det (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cf_valid),
        .o_ready (cf_ready),
        .i_adj   (cf_adj),
        .i_col   (cf_col),
        .o_valid (dt_valid),
        .i_ready (dt_ready),
        .o_dmag  (dt_dmag),
        .o_mag   (dt_mag),
        .o_sgn   (dt_sgn)
    );

    mi3_divider #(.DATA_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (dt_valid),
        .o_ready (dt_ready),
        .i_dmag  (dt_dmag),
        .i_mag   (dt_mag),
        .i_sgn   (dt_sgn),
        .o_valid (dv_valid),
        .i_ready (dv_ready),
        .o_q     (dv_q),
        .o_ovf   (dv_ovf),
        .o_sgn   (dv_sgn)
    );

    // Sign, saturation and the singular override form the output register.
    always_comb begin
        logic neg;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            neg = (dv_sgn.aneg[k] ^ dv_sgn.neg) && (dv_ovf[k] || (dv_q[k] != '0));
            if (!neg && (dv_ovf[k] || dv_q[k][W-1])) begin
                n_r[k] = {1'b0, {(W-1){1'b1}}};
                sat[k] = 1'b1;
            end else if (neg && (dv_ovf[k] || (dv_q[k][W-1] && (|dv_q[k][W-2:0])))) begin
                n_r[k] = {1'b1, {(W-1){1'b0}}};
                sat[k] = 1'b1;
            end else begin
                n_r[k] = neg ? W'(-dv_q[k]) : dv_q[k];
                sat[k] = 1'b0;
            end
            if (dv_sgn.zero) begin
                n_r[k] = '0;
            end
        end
        n_clip = (|sat) && !dv_sgn.zero;
    end

    assign dv_ready = !r_ov || o_inv.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (dv_ready) begin
            r_ov <= dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dv_ready) begin
            r_r    <= n_r;
            r_clip <= n_clip;
            r_sing <= dv_sgn.zero;
        end
    end

    assign o_inv.valid    = r_ov;
    assign o_inv.r00      = r_r[0];
    assign o_inv.r01      = r_r[1];
    assign o_inv.r02      = r_r[2];
    assign o_inv.r10      = r_r[3];
    assign o_inv.r11      = r_r[4];
    assign o_inv.r12      = r_r[5];
    assign o_inv.r20      = r_r[6];
    assign o_inv.r21      = r_r[7];
    assign o_inv.r22      = r_r[8];
    assign o_inv.singular = r_sing;
    assign o_inv.clipped  = r_clip;
endmodule
`default_nettype wire

FILE: sim/matrix_inverse_3x3_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// matrix_inverse_3x3_tb
// Self-checking bench for the pipelined 3x3 fixed-point matrix inverter.
// ----------------------------------------------------------------------------
// Matrices are driven through the input channel with random gaps. A 256-bit
// predictor computes the adjugate, the determinant and the saturated
// quotients of every accepted matrix, and a scoreboard compares each returned
// inverse field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3_tb;

    localparam int DW = mi3_pkg::DATA_WIDTH_DEF;
    localparam int FB = mi3_pkg::FRAC_BITS_DEF;
    localparam int N_RAND = 1030;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef logic signed [DW-1:0] t_word;
    typedef t_word t_mat [mi3_pkg::N_ENT];

    typedef struct {
        t_word ent [mi3_pkg::N_ENT];
        logic  singular;
        logic  clipped;
    } t_inverse;

    // Expected inverse of one matrix; 256 bits hold every intermediate value.
    function automatic t_inverse invert_matrix(t_mat m);
        logic signed [255:0] a [mi3_pkg::N_ENT];
        logic signed [255:0] adj [mi3_pkg::N_ENT];
        logic signed [255:0] det, num, dmag, quo, lim;
        logic neg;
        t_inverse r;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) a[k] = m[k];
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            adj[k] = a[mi3_pkg::MINOR_IDX[k][0]] * a[mi3_pkg::MINOR_IDX[k][1]]
                   - a[mi3_pkg::MINOR_IDX[k][2]] * a[mi3_pkg::MINOR_IDX[k][3]];
        end
        det = a[0] * adj[0] + a[3] * adj[1] + a[6] * adj[2];
        r.singular = (det == 0);
        r.clipped = 1'b0;
        for (int k = 0; k < mi3_pkg::N_ENT; k++) r.ent[k] = '0;
        if (r.singular) return r;
        dmag = (det < 0) ? -det : det;
        lim = 256'sd1 <<< (DW - 1);
        for (int k = 0; k < mi3_pkg::N_ENT; k++) begin
            num = (adj[k] < 0) ? -adj[k] : adj[k];
            quo = (num <<< (2 * FB)) / dmag;
            neg = ((adj[k] < 0) != (det < 0)) && (quo != 0);
            if (!neg && quo >= lim) begin
                r.ent[k] = {1'b0, {(DW-1){1'b1}}};
                r.clipped = 1'b1;
            end else if (neg && quo > lim) begin
                r.ent[k] = {1'b1, {(DW-1){1'b0}}};
                r.clipped = 1'b1;
            end else begin
                r.ent[k] = neg ? -quo[DW-1:0] : quo[DW-1:0];
            end
        end
        return r;
    endfunction

    class inverse_scoreboard;
        t_inverse pending [$];
        int mismatches;

        function void note_matrix(t_mat m);
            pending.push_back(invert_matrix(m));
        endfunction

        function void check_inverse(t_inverse got);
            t_inverse want;
            bit bad;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("ERROR: inverse with no matrix pending");
                return;
            end
            want = pending.pop_front();
            bad = (got.singular !== want.singular) || (got.clipped !== want.clipped);
            for (int k = 0; k < mi3_pkg::N_ENT; k++) bad |= (got.ent[k] !== want.ent[k]);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("ERROR: sing %b/%b clip %b/%b (expected/actual)",
                             want.singular, got.singular, want.clipped, got.clipped);
                    for (int k = 0; k < mi3_pkg::N_ENT; k++)
                        if (got.ent[k] !== want.ent[k])
                            $display("  entry %0d expected %h actual %h",
                                     k, want.ent[k], got.ent[k]);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    mi3_in_if  #(.DATA_WIDTH(DW)) mat_if ();
    mi3_out_if #(.DATA_WIDTH(DW)) inv_if ();

    matrix_inverse_3x3 #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mat   (mat_if.sink),
        .o_inv   (inv_if.source)
    );

    inverse_scoreboard sb = new();
    bit hold_output;
    int idle_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom_range(0, 4)) <<< FB;
            1: return -(t_word'($urandom_range(1, 4)) <<< FB);
            2: return t_word'($signed($urandom_range(0, 2047)) - 1024) <<< 10;
            3: return $urandom_range(0, 1) ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
            default: return t_word'($urandom);
        endcase
    endfunction

    // Valid stays high after a transaction unless a gap follows; callers drop
    // it before any pause.
    task automatic send_matrix(t_mat m);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0) begin
            mat_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        mat_if.valid <= 1'b1;
        {mat_if.a00, mat_if.a01, mat_if.a02, mat_if.a10, mat_if.a11, mat_if.a12,
         mat_if.a20, mat_if.a21, mat_if.a22} <= {m[0], m[1], m[2], m[3], m[4],
                                                 m[5], m[6], m[7], m[8]};
        do @(posedge i_clk); while (!mat_if.ready);
        sb.note_matrix(m);
        @(negedge i_clk);
    endtask

    task automatic send_rand(int n);
        t_mat m;
        int kind;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < mi3_pkg::N_ENT; k++) m[k] = rand_word();
            if (kind == 0) begin
                // Dependent rows make the determinant vanish, unless the row sum wraps.
                for (int c = 0; c < 3; c++) m[6+c] = m[c] + m[3+c];
            end else if (kind < 4) begin
                // Near-identity matrices keep the inverse in range.
                for (int k = 0; k < mi3_pkg::N_ENT; k++)
                    m[k] = t_word'($signed($urandom_range(0, 4095)) - 2048) <<< 4;
                for (int d = 0; d < 3; d++) m[4*d] += t_word'($urandom_range(1, 8)) <<< FB;
            end
            send_matrix(m);
        end
    endtask

    // Receiver: a random wait before each transaction, plus a long hold-off on request.
    initial begin
        int gap;
        inv_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            gap = $urandom_range(0, 7);
            if (gap != 0 || hold_output) begin
                inv_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
                while (hold_output) @(negedge i_clk);
            end
            inv_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(i_rst_n && inv_if.valid === 1'b1));
            @(negedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_inverse got;
        if (i_rst_n && inv_if.valid && inv_if.ready) begin
            got.ent = '{inv_if.r00, inv_if.r01, inv_if.r02, inv_if.r10, inv_if.r11,
                        inv_if.r12, inv_if.r20, inv_if.r21, inv_if.r22};
            got.singular = inv_if.singular;
            got.clipped = inv_if.clipped;
            sb.check_inverse(got);
        end
    end

    // Watchdog on cycles without any transaction.
    always @(posedge i_clk) begin
        if ((mat_if.valid && mat_if.ready) || (inv_if.valid && inv_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        t_mat m;
        i_rst_n = 1'b0;
        mat_if.valid = 1'b0;
        {mat_if.a00, mat_if.a01, mat_if.a02, mat_if.a10, mat_if.a11, mat_if.a12,
         mat_if.a20, mat_if.a21, mat_if.a22} = '0;
        hold_output = 1'b0;
        idle_cycles = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Identity, scaled identity, zero, singular, saturating and random cases.
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? t_word'(1) <<< FB : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? -(t_word'(2) <<< FB) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = t_word'(k + 1) <<< FB;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? t_word'(1) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? -t_word'(1) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? {1'b1, {(DW-1){1'b0}}} : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? {1'b0, {(DW-1){1'b1}}} : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = {1'b1, {(DW-1){1'b0}}};
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k == 2 || k == 4 || k == 6) ? t_word'(-1) : '0;
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? {1'b0, {(DW-1){1'b1}}} : t_word'(-1);
        send_matrix(m);
        for (int k = 0; k < 9; k++) m[k] = t_word'($urandom);
        send_matrix(m);

        send_rand(N_RAND / 3);

        // Hold the output off so the pipeline fills and stalls its input.
        fork
            begin
                hold_output = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_output = 1'b0;
            end
            begin
                send_rand(80);
                mat_if.valid <= 1'b0;
            end
        join

        // Pause until the pipeline drains.
        while (sb.pending.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        send_rand(N_RAND - N_RAND / 3 - 80);
        mat_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (DW + 20) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
